@@ src/nearest_geo_point_search_assert.svh @@
// Assertion macros shared by the nearest point search RTL.
`ifndef NEAREST_GEO_POINT_SEARCH_ASSERT_SVH
`define NEAREST_GEO_POINT_SEARCH_ASSERT_SVH

// Checks a property at every clock edge outside reset.
`define NGPS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checks that a condition holds in the cycle after a trigger.
`define NGPS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/ngps_pkg.sv @@
`timescale 1ns / 1ps

package ngps_pkg;

	// Width of the CORDIC datapath and of the multiplier operands.
	localparam int CW = 36;
	localparam int MW = 34;

	localparam int IDX_W = 6;
	localparam int IN_TDATA_W = 88;
	localparam int OUT_TDATA_W = 48;

	localparam logic [31:0] CORDIC_GAIN_Q30 = 32'd652032874;
	localparam logic [31:0] ONE_Q30 = 32'd1073741824;
	localparam logic [31:0] PI_R_CM = 32'd2001508680;
	localparam logic [31:0] BANG_DIV = 32'd3600000000;
	localparam logic [31:0] BANG_HALF = 32'd1800000000;
	localparam logic [MW-1:0] RND_HALF = MW'(32'd536870912);

	typedef struct packed {
		logic start;
		logic vector;
	} cor_cmd_t;

	typedef struct packed {
		logic start;
		logic rnd;
	} mul_cmd_t;

	// Arctangent of 2^-i in binary angle units (full turn = 2^32).
	function automatic logic [29:0] atan_val(input logic [5:0] i);
		logic [29:0] v;
		case (i)
			6'd0: v = 30'd536870912;
			6'd1: v = 30'd316933406;
			6'd2: v = 30'd167458907;
			6'd3: v = 30'd85004756;
			6'd4: v = 30'd42667331;
			6'd5: v = 30'd21354465;
			6'd6: v = 30'd10679838;
			6'd7: v = 30'd5340245;
			6'd8: v = 30'd2670163;
			6'd9: v = 30'd1335087;
			6'd10: v = 30'd667544;
			6'd11: v = 30'd333772;
			6'd12: v = 30'd166886;
			6'd13: v = 30'd83443;
			6'd14: v = 30'd41722;
			6'd15: v = 30'd20861;
			6'd16: v = 30'd10430;
			6'd17: v = 30'd5215;
			6'd18: v = 30'd2608;
			6'd19: v = 30'd1304;
			6'd20: v = 30'd652;
			6'd21: v = 30'd326;
			6'd22: v = 30'd163;
			6'd23: v = 30'd81;
			6'd24: v = 30'd41;
			6'd25: v = 30'd20;
			6'd26: v = 30'd10;
			6'd27: v = 30'd5;
			6'd28: v = 30'd3;
			6'd29: v = 30'd1;
			6'd30: v = 30'd1;
			default: v = 30'd0;
		endcase
		return v;
	endfunction

endpackage

@@ src/ngps_cordic.sv @@
`timescale 1ns / 1ps

module ngps_cordic #(
	parameter int ITER = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  ngps_pkg::cor_cmd_t              cmd,
	input  logic [31:0]                     ang,
	input  logic [ngps_pkg::CW-1:0]         vx,
	input  logic [ngps_pkg::CW-1:0]         vy,
	output logic                            busy,
	output logic                            done,
	output logic signed [ngps_pkg::CW-1:0]  sin_o,
	output logic signed [ngps_pkg::CW-1:0]  cos_o,
	output logic signed [ngps_pkg::CW-1:0]  z_o
);

	localparam int CW = ngps_pkg::CW;
	localparam int IW = $clog2(ITER);
	localparam logic signed [CW-1:0] ONE_C = CW'(ngps_pkg::ONE_Q30);
	localparam logic signed [CW-1:0] GAIN_C = CW'(ngps_pkg::CORDIC_GAIN_Q30);

	logic [IW-1:0] i_q;
	logic busy_q, done_q, neg_q, vec_q;
	logic signed [CW-1:0] x_q, y_q, z_q;
	logic signed [CW-1:0] xs, ys, at, z0;
	logic sub_mode;

	always_comb begin
		xs = x_q >>> i_q;
		ys = y_q >>> i_q;
		at = signed'(CW'(ngps_pkg::atan_val(6'(i_q))));
		z0 = signed'({{(CW-32){ang[31]}}, ang});
		sub_mode = vec_q ? (y_q <= 0) : (z_q >= 0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
			neg_q <= 1'b0;
			vec_q <= 1'b0;
			x_q <= '0;
			y_q <= '0;
			z_q <= '0;
		end else begin
			done_q <= busy_q && !cmd.start && (i_q == IW'(ITER - 1));
			if (cmd.start) begin
				busy_q <= 1'b1;
				i_q <= '0;
				vec_q <= cmd.vector;
				if (cmd.vector) begin
					x_q <= signed'(vx);
					y_q <= signed'(vy);
					z_q <= '0;
					neg_q <= 1'b0;
				end else begin
					x_q <= GAIN_C;
					y_q <= '0;
					// Angles beyond a quarter turn are folded by a half turn.
					if (z0 > ONE_C || z0 < -ONE_C) begin
						z_q <= (z0 > 0) ? z0 - (ONE_C <<< 1) : z0 + (ONE_C <<< 1);
						neg_q <= 1'b1;
					end else begin
						z_q <= z0;
						neg_q <= 1'b0;
					end
				end
			end else if (busy_q) begin
				if (sub_mode) begin
					x_q <= x_q - ys;
					y_q <= y_q + xs;
					z_q <= z_q - at;
				end else begin
					x_q <= x_q + ys;
					y_q <= y_q - xs;
					z_q <= z_q + at;
				end
				if (i_q == IW'(ITER - 1)) begin
					busy_q <= 1'b0;
				end else begin
					i_q <= i_q + IW'(1);
				end
			end
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign sin_o = neg_q ? -y_q : y_q;
	assign cos_o = neg_q ? -x_q : x_q;
	assign z_o = z_q;

endmodule

@@ src/ngps_mul.sv @@
`timescale 1ns / 1ps

module ngps_mul (
	input  logic                            clk,
	input  logic                            arst_n,
	input  ngps_pkg::mul_cmd_t              cmd,
	input  logic signed [ngps_pkg::MW-1:0]  a,
	input  logic signed [ngps_pkg::MW-1:0]  b,
	output logic                            busy,
	output logic                            done,
	output logic signed [ngps_pkg::MW-1:0]  p
);

	localparam int MW = ngps_pkg::MW;
	localparam int DG = 4;
	localparam int ND = (MW + DG - 1) / DG;
	localparam int BW = ND * DG;
	localparam int PW = 2 * MW;
	localparam int KW = $clog2(ND + 1);

	logic [MW-1:0] ma_q;
	logic [BW-1:0] mb_q;
	logic [PW-1:0] acc_q, acc_nx;
	logic [KW-1:0] cnt_q;
	logic busy_q, done_q, neg_q, rnd_q;
	logic signed [MW-1:0] p_q;
	logic signed [PW:0] prod, prod_r;
	logic [MW-1:0] abs_a, abs_b;

	always_comb begin
		abs_a = a[MW-1] ? MW'(-a) : MW'(a);
		abs_b = b[MW-1] ? MW'(-b) : MW'(b);
		// Horner step: one 4-bit digit of the multiplier, most significant first.
		acc_nx = (acc_q << DG) + PW'(ma_q * mb_q[BW-1 -: DG]);
		prod = neg_q ? -signed'({1'b0, acc_q}) : signed'({1'b0, acc_q});
		prod_r = prod + (rnd_q ? (PW+1)'(ngps_pkg::RND_HALF) : '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ma_q <= '0;
			mb_q <= '0;
			acc_q <= '0;
			cnt_q <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
			neg_q <= 1'b0;
			rnd_q <= 1'b0;
			p_q <= '0;
		end else begin
			done_q <= busy_q && !cmd.start && (cnt_q == '0);
			if (cmd.start) begin
				ma_q <= abs_a;
				mb_q <= BW'(abs_b);
				acc_q <= '0;
				cnt_q <= KW'(ND);
				neg_q <= a[MW-1] ^ b[MW-1];
				rnd_q <= cmd.rnd;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (cnt_q != '0) begin
					acc_q <= acc_nx;
					mb_q <= mb_q << DG;
					cnt_q <= cnt_q - KW'(1);
				end else begin
					p_q <= MW'(prod_r >>> 30);
					busy_q <= 1'b0;
				end
			end
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign p = p_q;

endmodule

@@ src/nearest_geo_point_search.sv @@
`timescale 1ns / 1ps
// Nearest reference point search. Load items (tuser = 0) store one table entry
// and give no result; query items (tuser = 1) return the group id and the
// haversine distance in centimeters of the nearest of the first entry_count
// entries, the earlier entry winning a tie, or found = 0 with a saturated
// distance when the table is empty. One item is handled at a time. A load
// takes a bit-serial angle conversion and one CORDIC pass for the stored
// cosine. The time a query spends on each searched entry is set by the
// shared CORDIC unit at one iteration per cycle, five passes of the 4-bit
// digit multiplier and the two-bit-per-cycle square root.
`include "nearest_geo_point_search_assert.svh"

module nearest_geo_point_search #(
	parameter int MAX_ENTRIES = 64,
	parameter int CORDIC_ITERATIONS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [6:0]  cfg_wdata,    // entry_count
	input  logic        s_tvalid,
	output logic        s_tready,
	// entry_index[5:0], lat[36:6], lon[68:37], pair_id_in[84:69], zero fill
	input  logic [ngps_pkg::IN_TDATA_W-1:0] s_tdata,
	input  logic [0:0]  s_tuser,      // func
	output logic        m_tvalid,
	input  logic        m_tready,
	// nearest_pair_id[15:0], distance_cm[47:16]
	output logic [ngps_pkg::OUT_TDATA_W-1:0] m_tdata,
	output logic [0:0]  m_tuser       // found
);

	localparam int CW = ngps_pkg::CW;
	localparam int MW = ngps_pkg::MW;
	localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int NW = $clog2(MAX_ENTRIES + 1);
	localparam logic signed [MW:0] H_ONE = (MW+1)'(ngps_pkg::ONE_Q30);
	localparam logic signed [CW-1:0] Z_ONE = CW'(ngps_pkg::ONE_Q30);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_CONV = 4'd1;
	localparam logic [3:0] ST_LCOS = 4'd2;
	localparam logic [3:0] ST_QCOS = 4'd3;
	localparam logic [3:0] ST_RD   = 4'd4;
	localparam logic [3:0] ST_RDW  = 4'd5;
	localparam logic [3:0] ST_S1   = 4'd6;
	localparam logic [3:0] ST_P1   = 4'd7;
	localparam logic [3:0] ST_S2   = 4'd8;
	localparam logic [3:0] ST_P3   = 4'd9;
	localparam logic [3:0] ST_P2   = 4'd10;
	localparam logic [3:0] ST_P4   = 4'd11;
	localparam logic [3:0] ST_SQRT = 4'd12;
	localparam logic [3:0] ST_VEC  = 4'd13;
	localparam logic [3:0] ST_DIST = 4'd14;
	localparam logic [3:0] ST_OUT  = 4'd15;

	typedef struct packed {
		logic [32:0] rem;
		logic [30:0] root;
	} sq_t;

	// One digit of the restoring square root: two radicand bits per call.
	function automatic sq_t sq_step(input sq_t s, input logic [1:0] d);
		logic [34:0] r2;
		logic [34:0] tr;
		sq_t o;
		r2 = {s.rem, d};
		tr = {2'b00, s.root, 2'b01};
		if (r2 >= tr) begin
			o.rem = 33'(r2 - tr);
			o.root = {s.root[29:0], 1'b1};
		end else begin
			o.rem = r2[32:0];
			o.root = {s.root[29:0], 1'b0};
		end
		return o;
	endfunction

	logic [3:0] state_q;
	logic [4:0] cnt_q;
	logic [6:0] cfg_q;
	logic func_q;
	logic [ngps_pkg::IDX_W-1:0] idx_q;
	logic [15:0] pid_q;
	logic sgn_lat_q, sgn_lon_q;
	logic [31:0] num_q, dr_lat_q, dr_lon_q, dq_lat_q, dq_lon_q;
	logic [NW-1:0] n_q, ent_q, ent_nx, n_nx;
	logic signed [MW-1:0] qcos_q, p1_q, p3_q, mul_a_q, mul_b_q;
	logic [31:0] ang_q;
	logic [61:0] sa_q, sb_q;
	sq_t sq_a_q, sq_b_q;
	logic [31:0] best_d_q, dist_q;
	logic [15:0] best_id_q, id_q;
	logic found_q, m_tvalid_q;
	ngps_pkg::cor_cmd_t cor_cmd_q;
	ngps_pkg::mul_cmd_t mul_cmd_q;

	logic [31:0] mem_lat [MAX_ENTRIES];
	logic [31:0] mem_lon [MAX_ENTRIES];
	logic [15:0] mem_grp [MAX_ENTRIES];
	logic signed [MW-1:0] mem_cos [MAX_ENTRIES];
	logic [31:0] rd_lat_q, rd_lon_q;
	logic [15:0] rd_grp_q;
	logic signed [MW-1:0] rd_cos_q;
	logic mem_we;
	logic [AW-1:0] wr_addr;

	logic signed [30:0] in_lat;
	logic signed [31:0] in_lon;
	logic signed [32:0] lat_x, lon_x, lat_neg, lon_neg;
	logic [32:0] t_lat, t_lon;
	logic ge_lat, ge_lon;
	logic [31:0] lat_b, lon_b, dlat, dlon;
	logic [31:0] cor_ang;
	logic cor_busy, cor_done, mul_busy, mul_done;
	logic cor_go, cor_vec, mul_go, mul_rnd;
	logic signed [CW-1:0] cor_sin, cor_cos, cor_z;
	logic signed [MW-1:0] mul_p;
	logic signed [MW:0] hs;
	logic [30:0] h, h_inv, zc;
	logic [31:0] d_now;
	logic out_load;

	always_comb begin
		in_lat = signed'(s_tdata[36:6]);
		in_lon = signed'(s_tdata[68:37]);
		lat_x = 33'(in_lat);
		lon_x = 33'(in_lon);
		lat_neg = -lat_x;
		lon_neg = -lon_x;
		// Long division of (|v| << 32) + half divisor, one quotient bit a cycle.
		t_lat = {dr_lat_q, num_q[31]};
		t_lon = {dr_lon_q, num_q[31]};
		ge_lat = t_lat >= 33'(ngps_pkg::BANG_DIV);
		ge_lon = t_lon >= 33'(ngps_pkg::BANG_DIV);
		lat_b = sgn_lat_q ? 32'd0 - dq_lat_q : dq_lat_q;
		lon_b = sgn_lon_q ? 32'd0 - dq_lon_q : dq_lon_q;
		dlat = rd_lat_q - lat_b;
		dlon = rd_lon_q - lon_b;
		cor_ang = (state_q == ST_LCOS || state_q == ST_QCOS) ? lat_b : ang_q;
		n_nx = (int'(cfg_q) > MAX_ENTRIES) ? NW'(MAX_ENTRIES) : NW'(cfg_q);
		ent_nx = ent_q + NW'(1);
		hs = (MW+1)'(p1_q) + (MW+1)'(mul_p);
		if (hs < 0) begin
			h = '0;
		end else if (hs > H_ONE) begin
			h = 31'(ngps_pkg::ONE_Q30);
		end else begin
			h = hs[30:0];
		end
		h_inv = 31'(ngps_pkg::ONE_Q30) - h;
		if (cor_z < 0) begin
			zc = '0;
		end else if (cor_z > Z_ONE) begin
			zc = 31'(ngps_pkg::ONE_Q30);
		end else begin
			zc = cor_z[30:0];
		end
		d_now = mul_p[31:0];
		out_load = (state_q == ST_OUT) && (!m_tvalid_q || m_tready);
		mem_we = (state_q == ST_LCOS) && cor_done && (int'(idx_q) < MAX_ENTRIES);
		wr_addr = AW'(idx_q);
		// Start pulses for the shared CORDIC and multiplier units.
		cor_go = (state_q == ST_CONV && cnt_q == 5'd31) || (state_q == ST_RDW) ||
			(state_q == ST_P1 && mul_done) || (state_q == ST_SQRT && cnt_q == 5'd30);
		cor_vec = (state_q == ST_SQRT);
		mul_go = (cor_done && (state_q == ST_S1 || state_q == ST_S2 || state_q == ST_VEC)) ||
			(mul_done && (state_q == ST_P3 || state_q == ST_P2));
		mul_rnd = (state_q == ST_VEC);
	end

	ngps_cordic #(
		.ITER(CORDIC_ITERATIONS)
	) u_cordic (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cor_cmd_q),
		.ang(cor_ang),
		.vx(CW'(sq_b_q.root)),
		.vy(CW'(sq_a_q.root)),
		.busy(cor_busy),
		.done(cor_done),
		.sin_o(cor_sin),
		.cos_o(cor_cos),
		.z_o(cor_z)
	);

	ngps_mul u_mul (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(mul_cmd_q),
		.a(mul_a_q),
		.b(mul_b_q),
		.busy(mul_busy),
		.done(mul_done),
		.p(mul_p)
	);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_lat[wr_addr] <= lat_b;
			mem_lon[wr_addr] <= lon_b;
			mem_grp[wr_addr] <= pid_q;
			mem_cos[wr_addr] <= MW'(cor_cos);
		end
		if (state_q == ST_RD) begin
			rd_lat_q <= mem_lat[ent_q[AW-1:0]];
			rd_lon_q <= mem_lon[ent_q[AW-1:0]];
			rd_grp_q <= mem_grp[ent_q[AW-1:0]];
			rd_cos_q <= mem_cos[ent_q[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			cfg_q <= '0;
			func_q <= 1'b0;
			idx_q <= '0;
			pid_q <= '0;
			sgn_lat_q <= 1'b0;
			sgn_lon_q <= 1'b0;
			num_q <= '0;
			dr_lat_q <= '0;
			dr_lon_q <= '0;
			dq_lat_q <= '0;
			dq_lon_q <= '0;
			n_q <= '0;
			ent_q <= '0;
			qcos_q <= '0;
			p1_q <= '0;
			p3_q <= '0;
			mul_a_q <= '0;
			mul_b_q <= '0;
			ang_q <= '0;
			sa_q <= '0;
			sb_q <= '0;
			sq_a_q <= '0;
			sq_b_q <= '0;
			best_d_q <= '1;
			best_id_q <= '0;
			dist_q <= '0;
			id_q <= '0;
			found_q <= 1'b0;
			m_tvalid_q <= 1'b0;
			cor_cmd_q <= '0;
			mul_cmd_q <= '0;
		end else begin
			cor_cmd_q <= '{start: cor_go, vector: cor_vec};
			mul_cmd_q <= '{start: mul_go, rnd: mul_rnd};
			if (cfg_we) begin
				cfg_q <= cfg_wdata;
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						func_q <= s_tuser[0];
						idx_q <= s_tdata[5:0];
						pid_q <= s_tdata[84:69];
						sgn_lat_q <= lat_x[32];
						sgn_lon_q <= lon_x[32];
						dr_lat_q <= lat_x[32] ? lat_neg[31:0] : lat_x[31:0];
						dr_lon_q <= lon_x[32] ? lon_neg[31:0] : lon_x[31:0];
						num_q <= ngps_pkg::BANG_HALF;
						cnt_q <= '0;
						state_q <= ST_CONV;
					end
				end
				ST_CONV: begin
					dr_lat_q <= ge_lat ? 32'(t_lat - 33'(ngps_pkg::BANG_DIV)) : t_lat[31:0];
					dr_lon_q <= ge_lon ? 32'(t_lon - 33'(ngps_pkg::BANG_DIV)) : t_lon[31:0];
					dq_lat_q <= {dq_lat_q[30:0], ge_lat};
					dq_lon_q <= {dq_lon_q[30:0], ge_lon};
					num_q <= num_q << 1;
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd31) begin
						state_q <= func_q ? ST_QCOS : ST_LCOS;
					end
				end
				ST_LCOS: begin
					if (cor_done) begin
						state_q <= ST_IDLE;
					end
				end
				ST_QCOS: begin
					if (cor_done) begin
						qcos_q <= MW'(cor_cos);
						n_q <= n_nx;
						ent_q <= '0;
						best_d_q <= '1;
						best_id_q <= '0;
						state_q <= (n_nx == '0) ? ST_OUT : ST_RD;
					end
				end
				ST_RD: begin
					state_q <= ST_RDW;
				end
				ST_RDW: begin
					ang_q <= {dlat[31], dlat[31:1]};
					state_q <= ST_S1;
				end
				ST_S1: begin
					if (cor_done) begin
						mul_a_q <= MW'(cor_sin);
						mul_b_q <= MW'(cor_sin);
						state_q <= ST_P1;
					end
				end
				ST_P1: begin
					if (mul_done) begin
						p1_q <= mul_p;
						ang_q <= {dlon[31], dlon[31:1]};
						state_q <= ST_S2;
					end
				end
				ST_S2: begin
					if (cor_done) begin
						mul_a_q <= MW'(cor_sin);
						mul_b_q <= MW'(cor_sin);
						state_q <= ST_P3;
					end
				end
				ST_P3: begin
					if (mul_done) begin
						p3_q <= mul_p;
						mul_a_q <= qcos_q;
						mul_b_q <= rd_cos_q;
						state_q <= ST_P2;
					end
				end
				ST_P2: begin
					if (mul_done) begin
						mul_a_q <= mul_p;
						mul_b_q <= p3_q;
						state_q <= ST_P4;
					end
				end
				ST_P4: begin
					if (mul_done) begin
						sa_q <= {1'b0, h, 30'd0};
						sb_q <= {1'b0, h_inv, 30'd0};
						sq_a_q <= '0;
						sq_b_q <= '0;
						cnt_q <= '0;
						state_q <= ST_SQRT;
					end
				end
				ST_SQRT: begin
					sq_a_q <= sq_step(sq_a_q, sa_q[61:60]);
					sq_b_q <= sq_step(sq_b_q, sb_q[61:60]);
					sa_q <= sa_q << 2;
					sb_q <= sb_q << 2;
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd30) begin
						state_q <= ST_VEC;
					end
				end
				ST_VEC: begin
					if (cor_done) begin
						mul_a_q <= MW'(zc);
						mul_b_q <= MW'(ngps_pkg::PI_R_CM);
						state_q <= ST_DIST;
					end
				end
				ST_DIST: begin
					if (mul_done) begin
						if (ent_q == '0 || d_now < best_d_q) begin
							best_d_q <= d_now;
							best_id_q <= rd_grp_q;
						end
						ent_q <= ent_nx;
						state_q <= (ent_nx == n_q) ? ST_OUT : ST_RD;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						found_q <= (n_q != '0);
						dist_q <= best_d_q;
						id_q <= best_id_q;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata = {dist_q, id_q};
	assign m_tuser = found_q;

	`NGPS_ASSERT(a_cor_free, (cor_cmd_q.start |-> !cor_busy), "CORDIC started while busy")
	`NGPS_ASSERT(a_mul_free, (mul_cmd_q.start |-> !mul_busy), "multiplier started while busy")
	`NGPS_ASSERT(a_ent_range, ((state_q == ST_RD) |-> (ent_q < n_q)), "entry read past count")
	`NGPS_ASSERT_NEXT(a_out_idle, out_load, (state_q == ST_IDLE && m_tvalid_q), "result lost")
	`NGPS_ASSERT(a_empty, ((m_tvalid_q && !found_q) |-> (dist_q == '1 && id_q == '0)), "empty result not saturated")

endmodule

@@ tb/nearest_geo_point_search_tb.sv @@
`timescale 1ns / 1ps

typedef struct {
	logic        found;
	logic [15:0] pair_id;
	logic [31:0] dist_cm;
} geo_result_t;

class nearest_point_scoreboard;
	logic [31:0] slot_lat[64];
	logic [31:0] slot_lon[64];
	logic [15:0] slot_group[64];
	int unsigned search_count;
	geo_result_t pending_results[$];
	int errors;

	longint atan_steps[40] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
		41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10,
		5, 3, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0};

	function new();
		search_count = 0;
		errors = 0;
		foreach (slot_lat[i]) begin
			slot_lat[i] = '0;
			slot_lon[i] = '0;
			slot_group[i] = '0;
		end
	endfunction

	function longint q30_mul(longint a, longint b);
		return (a * b) >>> 30;
	endfunction

	// Degrees times 1e7 to a binary angle, rounding half away from zero.
	function logic [31:0] binary_angle(longint v);
		longint unsigned m, q;
		m = (v < 0) ? longint'(-v) : longint'(v);
		q = ((m << 32) + 64'd1800000000) / 64'd3600000000;
		return (v < 0) ? 32'(-q) : 32'(q);
	endfunction

	function void sin_cos(logic [31:0] ang, output longint s, output longint c);
		longint z, x, y, xn, yn;
		bit flip;
		z = longint'($signed(ang));
		flip = 0;
		x = 652032874;
		y = 0;
		if (z > (64'sd1 << 30) || z < -(64'sd1 << 30)) begin
			z = (z > 0) ? z - (64'sd1 << 31) : z + (64'sd1 << 31);
			flip = 1;
		end
		for (int i = 0; i < 32; i++) begin
			if (z >= 0) begin
				xn = x - (y >>> i); yn = y + (x >>> i); z -= atan_steps[i];
			end else begin
				xn = x + (y >>> i); yn = y - (x >>> i); z += atan_steps[i];
			end
			x = xn; y = yn;
		end
		s = flip ? -y : y;
		c = flip ? -x : x;
	endfunction

	function longint floor_root(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return longint'(r);
	endfunction

	function longint half_angle(longint y, longint x);
		longint z, xn, yn;
		z = 0;
		for (int i = 0; i < 32; i++) begin
			if (y > 0) begin
				xn = x + (y >>> i); yn = y - (x >>> i); z += atan_steps[i];
			end else begin
				xn = x - (y >>> i); yn = y + (x >>> i); z -= atan_steps[i];
			end
			x = xn; y = yn;
		end
		return z;
	endfunction

	function logic [31:0] great_circle_cm(logic [31:0] qlat, longint qcos, logic [31:0] qlon,
			logic [31:0] elat, logic [31:0] elon);
		longint s1, c1, s2, c2, junk, ecos, h, z;
		logic [31:0] d;
		longint unsigned prod;
		d = elat - qlat;
		sin_cos(32'(longint'($signed(d)) >>> 1), s1, c1);
		d = elon - qlon;
		sin_cos(32'(longint'($signed(d)) >>> 1), s2, c2);
		sin_cos(elat, junk, ecos);
		h = q30_mul(s1, s1) + q30_mul(q30_mul(qcos, ecos), q30_mul(s2, s2));
		if (h < 0) h = 0;
		if (h > (64'sd1 << 30)) h = 64'sd1 << 30;
		z = half_angle(floor_root(longint'(h) << 30), floor_root(((64'sd1 << 30) - h) << 30));
		if (z < 0) z = 0;
		if (z > (64'sd1 << 30)) z = 64'sd1 << 30;
		prod = (longint'(z) * 64'd2001508680 + (64'd1 << 29)) >> 30;
		return prod[31:0];
	endfunction

	function void note_item(logic func, logic [5:0] idx, logic [30:0] lat, logic [31:0] lon,
			logic [15:0] pid);
		logic [31:0] qlat, qlon, dd;
		longint qs, qc;
		int unsigned n;
		geo_result_t r;
		qlat = binary_angle(longint'($signed(lat)));
		qlon = binary_angle(longint'($signed(lon)));
		if (func == 1'b0) begin
			slot_lat[idx] = qlat;
			slot_lon[idx] = qlon;
			slot_group[idx] = pid;
			return;
		end
		n = (search_count > 64) ? 64 : search_count;
		r.found = (n != 0);
		r.pair_id = '0;
		r.dist_cm = 32'hFFFF_FFFF;
		sin_cos(qlat, qs, qc);
		for (int i = 0; i < n; i++) begin
			dd = great_circle_cm(qlat, qc, qlon, slot_lat[i], slot_lon[i]);
			// Strict compare keeps the earlier entry on a tie.
			if (i == 0 || dd < r.dist_cm) begin
				r.dist_cm = dd;
				r.pair_id = slot_group[i];
			end
		end
		pending_results = {pending_results, r};
	endfunction

	function void check_result(logic found, logic [47:0] data);
		geo_result_t e;
		if (pending_results.size() == 0) begin
			$display("%0t: unexpected result found=%0d data=%h", $time, found, data);
			errors++;
			return;
		end
		e = pending_results.pop_front();
		if (found !== e.found) begin
			$display("%0t: found expected %0d actual %0d", $time, e.found, found);
			errors++;
		end
		if (data[15:0] !== e.pair_id) begin
			$display("%0t: pair id expected %0d actual %0d", $time, e.pair_id, data[15:0]);
			errors++;
		end
		if (data[47:16] !== e.dist_cm) begin
			$display("%0t: distance expected %0d actual %0d", $time, e.dist_cm, data[47:16]);
			errors++;
		end
	endfunction
endclass

module nearest_geo_point_search_tb;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [6:0] cfg_wdata;
	logic s_tvalid;
	logic s_tready;
	logic [ngps_pkg::IN_TDATA_W-1:0] s_tdata;
	logic [0:0] s_tuser;
	logic m_tvalid;
	logic m_tready;
	logic [ngps_pkg::OUT_TDATA_W-1:0] m_tdata;
	logic [0:0] m_tuser;

	nearest_point_scoreboard sb;
	bit no_idle;
	bit long_hold;
	int stall_left;

	nearest_geo_point_search u_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("nearest_geo_point_search verification failed");
		$finish;
	end

	task automatic send_item(logic func, logic [5:0] idx, logic [30:0] lat, logic [31:0] lon,
			logic [15:0] pid);
		if (!no_idle && $urandom_range(0, 3) == 0) begin
			s_tvalid = 0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
		end
		s_tvalid = 1;
		s_tuser = func;
		s_tdata = '0;
		s_tdata[5:0] = idx;
		s_tdata[36:6] = lat;
		s_tdata[68:37] = lon;
		s_tdata[84:69] = pid;
		do @(posedge clk); while (!s_tready);
		sb.note_item(func, idx, lat, lon, pid);
		@(negedge clk);
	endtask

	task automatic load_entry(logic [5:0] idx, longint lat, longint lon, logic [15:0] pid);
		send_item(1'b0, idx, 31'(lat), 32'(lon), pid);
	endtask

	task automatic query_at(longint lat, longint lon);
		send_item(1'b1, 6'($urandom), 31'(lat), 32'(lon), 16'($urandom));
	endtask

	// Waits for all results, then for the tail of any load still in flight.
	task automatic drain();
		s_tvalid = 0;
		while (sb.pending_results.size() != 0) @(negedge clk);
		repeat (300) @(negedge clk);
	endtask

	task automatic set_count(int unsigned n);
		drain();
		cfg_we = 1;
		cfg_wdata = 7'(n);
		@(negedge clk);
		cfg_we = 0;
		sb.search_count = n;
	endtask

	function automatic longint rand_lat();
		if ($urandom_range(0, 7) == 0) return longint'($signed(31'($urandom)));
		return longint'($urandom_range(0, 1800000000)) - 900000000;
	endfunction

	function automatic longint rand_lon();
		if ($urandom_range(0, 7) == 0) return longint'($signed(32'($urandom)));
		return longint'($urandom_range(0, 3600000000)) - 1800000000;
	endfunction

	task automatic random_item();
		if ($urandom_range(0, 1) == 0)
			load_entry(6'($urandom), rand_lat(), rand_lon(), 16'($urandom));
		else
			query_at(rand_lat(), rand_lon());
	endtask

	// Result side: sample at the rising edge, change ready at the falling edge.
	initial begin
		m_tready = 0;
		stall_left = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) sb.check_result(m_tuser[0], m_tdata);
			@(negedge clk);
			if (long_hold) begin
				long_hold = 0;
				stall_left = 3000;
			end
			if (stall_left > 0) begin
				m_tready = 0;
				stall_left--;
			end else if (!no_idle && $urandom_range(0, 4) == 0) begin
				m_tready = 0;
				stall_left = $urandom_range(0, 7);
			end else begin
				m_tready = 1;
			end
		end
	end

	initial begin
		sb = new();
		no_idle = 0;
		long_hold = 0;
		arst_n = 0;
		cfg_we = 0;
		cfg_wdata = '0;
		s_tvalid = 0;
		s_tdata = '0;
		s_tuser = '0;
		repeat (9) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		set_count(0);
		query_at(0, 0);
		load_entry(0, 900000000, 1800000000, 16'hFFFF);
		load_entry(1, -900000000, -1800000000, 16'h0000);
		load_entry(2, 0, 0, 16'h1234);
		load_entry(3, 0, 0, 16'h5678);
		load_entry(4, -(64'sd1 << 30), -(64'sd1 << 31), 16'hAAAA);
		load_entry(5, (64'sd1 << 30) - 1, (64'sd1 << 31) - 1, 16'h5555);
		set_count(6);
		query_at(0, 0);
		query_at(900000000, 0);
		query_at(-900000000, 1800000000);
		query_at(0, 1800000000);
		query_at((64'sd1 << 30) - 1, -(64'sd1 << 31));
		query_at(-(64'sd1 << 30), (64'sd1 << 31) - 1);
		set_count(1);
		query_at(-900000000, -1800000000);
		query_at(123456789, -987654321);

		// Fill every slot so that any count is legal from here on.
		for (int i = 6; i < 64; i++) load_entry(6'(i), rand_lat(), rand_lon(), 16'($urandom));
		set_count(64);
		query_at(rand_lat(), rand_lon());
		query_at(rand_lat(), rand_lon());
		set_count(127);
		query_at(rand_lat(), rand_lon());

		for (int ph = 0; ph < 4; ph++) begin
			set_count($urandom_range(0, 8));
			if (ph == 1) long_hold = 1;
			if (ph == 3) no_idle = 1;
			for (int k = 0; k < 6; k++) random_item();
		end

		drain();
		if (sb.errors == 0 && sb.pending_results.size() == 0) begin
			$display("nearest_geo_point_search verification clean");
		end else begin
			$display("nearest_geo_point_search verification failed");
		end
		$finish;
	end
endmodule

@@ filelist.f @@
+incdir+src
src/ngps_pkg.sv
src/ngps_cordic.sv
src/ngps_mul.sv
src/nearest_geo_point_search.sv
tb/nearest_geo_point_search_tb.sv
